// File: design/cit_pkg.sv
// Shared constants and types for the complex index interpolation table.
package cit_pkg;
  localparam int TableDepth = 64;
  localparam int AddrW = $clog2(TableDepth);
  localparam int CountW = $clog2(TableDepth + 1);
  localparam int KeyW = 20;
  localparam int ValW = 16;

  localparam logic [1:0] CmdClear = 2'd0;
  localparam logic [1:0] CmdInsert = 2'd1;
  localparam logic [1:0] CmdQuery = 2'd2;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StDup = 2'd3;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [2*ValW-1:0] val;
  } entry_t;

  // Request to the divider: start strobe and span.
  typedef struct packed {
    logic start;
    logic [KeyW-1:0] span;
  } div_req_t;
endpackage

// File: design/cit_store.sv
// Entry memory: one write port, one registered read port.
module cit_store (
  input  logic clk,
  input  logic we,
  input  logic [cit_pkg::AddrW-1:0] waddr,
  input  cit_pkg::entry_t wdata,
  input  logic [cit_pkg::AddrW-1:0] raddr,
  output cit_pkg::entry_t rdata
);
  import cit_pkg::*;

  entry_t mem [TableDepth];

  // Write and read the entry array.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/cit_lerp.sv
// Serial interpolation of one part: rounded (dv*off)/span by restoring division.
module cit_lerp (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [cit_pkg::ValW-1:0] v0,
  input  logic signed [cit_pkg::ValW-1:0] v1,
  input  logic [cit_pkg::KeyW-1:0] off,
  input  logic [cit_pkg::KeyW-1:0] span,
  output logic done,
  output logic signed [cit_pkg::ValW-1:0] result
);
  import cit_pkg::*;

  localparam int NumW = ValW + 1 + KeyW + 1;
  localparam int StepW = $clog2(NumW + 1);

  logic busy;
  logic neg;
  logic [NumW-1:0] num;
  logic [KeyW:0] rem;
  logic [KeyW-1:0] den;
  logic [StepW-1:0] step;
  logic signed [ValW-1:0] base;
  logic signed [ValW:0] dv;
  logic [2*KeyW+ValW:0] prod;
  logic [KeyW+1:0] trial;
  logic [KeyW+1:0] rem_sh;

  assign dv = {v1[ValW-1], v1} - {v0[ValW-1], v0};
  assign prod = (2*KeyW+ValW+1)'(dv[ValW] ? -dv : dv) * (2*KeyW+ValW+1)'(off);
  assign rem_sh = {rem, num[NumW-1]};
  assign trial = rem_sh - {2'b0, den};

  // Shift one quotient bit per cycle; numerator doubled plus span gives rounding.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= StepW'(NumW);
        neg <= dv[ValW];
        base <= v0;
        den <= span;
        rem <= '0;
        num <= NumW'({prod, 1'b0}) + NumW'(span);
      end else if (busy) begin
        if (!trial[KeyW+1]) begin
          rem <= trial[KeyW:0];
          num <= {num[NumW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[KeyW:0];
          num <= {num[NumW-2:0], 1'b0};
        end
        step <= step - StepW'(1);
        if (step == StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient of (2p+s)/(2s) = floor((p+s/2)/s) after dropping bit 0.
  always_comb begin
    logic [NumW-1:0] q;
    q = {1'b0, num[NumW-1:1]};
    result = neg ? base - ValW'(q) : base + ValW'(q);
  end
endmodule

// File: design/cit_eps.sv
// Square of the complex index, rounded to Q7.12 and saturated; the products and the result are registered.
module cit_eps (
  input  logic clk,
  input  logic signed [cit_pkg::ValW-1:0] re,
  input  logic signed [cit_pkg::ValW-1:0] im,
  output logic signed [19:0] eps_re,
  output logic signed [19:0] eps_im
);
  import cit_pkg::*;

  logic signed [31:0] rr, ii, ri;
  logic signed [33:0] xr, xi;

  // Register the products.
  always_ff @(posedge clk) begin
    rr <= re * re;
    ii <= im * im;
    ri <= re * im;
  end

  assign xr = 34'(rr) - 34'(ii) + 34'sd2048;
  assign xi = {ri[31], ri, 1'b0} + 34'sd2048;

  function automatic logic signed [19:0] sat(input logic signed [33:0] x);
    logic signed [21:0] q;
    q = x[33:12];
    if (q > 22'sd524287) sat = 20'sd524287;
    else if (q < -22'sd524288) sat = -20'sd524288;
    else sat = q[19:0];
  endfunction

  // Register the rounded, saturated epsilon.
  always_ff @(posedge clk) begin
    eps_re <= sat(xr);
    eps_im <= sat(xi);
  end
endmodule

// File: design/complex_index_interpolation_table.sv
// Top level of the complex index interpolation table.
// Keeps up to 64 entries sorted by wavelength in a single-port-read memory.
// Each request is handled alone; every memory read is issued, then its
// registered data is checked. Clear and the unused command go straight to
// the output register. Insert scans the table entry by entry, then shifts
// the entries above the slot up by one, each read and then written, and
// finally places the new entry. Query scans to the bracket, fetches both
// neighbors (S_LOW, S_HIGH), runs the two 38-step bit-serial dividers for
// the interpolated value and the squaring for epsilon (S_EPS1, S_EPS2).
// An exact hit skips the divider. The memory read port and the divider set
// the rate. The result is held in an output register until taken; no new
// request is accepted until then.
module complex_index_interpolation_table (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] command,
  input  logic [19:0] key_wavelength,
  input  logic signed [15:0] index_real_in,
  input  logic signed [15:0] index_imag_in,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] status,
  output logic signed [15:0] index_real_out,
  output logic signed [15:0] index_imag_out,
  output logic signed [19:0] eps_real_out,
  output logic signed [19:0] eps_imag_out
);
  import cit_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_SHIFT = 9'b000000100,
    S_LOW   = 9'b000001000,
    S_HIGH  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_EPS1  = 9'b001000000,
    S_EPS2  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic [1:0] cmd;
  logic [KeyW-1:0] w;
  logic [2*ValW-1:0] wval;
  logic [CountW-1:0] count;
  logic [CountW-1:0] pos;
  logic [CountW-1:0] sh;
  logic rd_pend;
  logic [KeyW-1:0] k0;
  logic [2*ValW-1:0] v0;

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  entry_t wdata, rdata;
  div_req_t dreq;
  logic done_re, done_im;
  logic signed [ValW-1:0] lre, lim;
  logic signed [ValW-1:0] sre, sim;
  logic signed [19:0] ere, eim;

  cit_store u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign dreq.start = (state == S_HIGH) && rd_pend;
  assign dreq.span = rdata.key - k0;

  cit_lerp u_lre (
    .clk(clk), .rst(rst), .start(dreq.start), .v0(v0[31:16]), .v1(rdata.val[31:16]),
    .off(w - k0), .span(dreq.span), .done(done_re), .result(lre)
  );
  cit_lerp u_lim (
    .clk(clk), .rst(rst), .start(dreq.start), .v0(v0[15:0]), .v1(rdata.val[15:0]),
    .off(w - k0), .span(dreq.span), .done(done_im), .result(lim)
  );
  cit_eps u_eps (.clk(clk), .re(sre), .im(sim), .eps_re(ere), .eps_im(eim));

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // Drive the memory ports.
  always_comb begin
    we = 1'b0;
    waddr = sh[AddrW-1:0];
    wdata = rdata;
    raddr = pos[AddrW-1:0];
    if (state == S_SHIFT) begin
      if (rd_pend) begin
        we = 1'b1;
        waddr = AddrW'(sh);
      end else if (sh == pos) begin
        we = 1'b1;
        waddr = pos[AddrW-1:0];
        wdata.key = w;
        wdata.val = wval;
      end
      raddr = AddrW'(sh - CountW'(1));
    end else if (state == S_LOW) begin
      raddr = AddrW'(pos - CountW'(1));
    end
  end

  // Sequence one request at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd <= command;
            w <= key_wavelength;
            wval <= {index_real_in, index_imag_in};
            pos <= '0;
            rd_pend <= 1'b0;
            status <= StOk;
            index_real_out <= '0;
            index_imag_out <= '0;
            eps_real_out <= '0;
            eps_imag_out <= '0;
            if (command == CmdClear) begin
              count <= '0;
              state <= S_OUT;
            end else if (command == CmdInsert || command == CmdQuery) begin
              state <= S_SCAN;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_SCAN: begin
          // Read entry pos; check it in the next cycle.
          if (!rd_pend) begin
            if (pos >= count) begin
              if (cmd == CmdInsert) begin
                if (count == CountW'(TableDepth)) begin
                  status <= StFull;
                  state <= S_OUT;
                end else begin
                  sh <= count;
                  state <= S_SHIFT;
                end
              end else begin
                status <= StRange;
                state <= S_OUT;
              end
            end else begin
              rd_pend <= 1'b1;
            end
          end else begin
            rd_pend <= 1'b0;
            if (rdata.key == w) begin
              if (cmd == CmdInsert) begin
                status <= StDup;
              end else begin
                index_real_out <= rdata.val[31:16];
                index_imag_out <= rdata.val[15:0];
                sre <= rdata.val[31:16];
                sim <= rdata.val[15:0];
                state <= S_EPS1;
              end
              if (cmd == CmdInsert) state <= S_OUT;
            end else if (rdata.key > w) begin
              if (cmd == CmdInsert) begin
                if (count == CountW'(TableDepth)) begin
                  status <= StFull;
                  state <= S_OUT;
                end else begin
                  sh <= count;
                  state <= S_SHIFT;
                end
              end else if (pos == '0) begin
                status <= StRange;
                state <= S_OUT;
              end else begin
                state <= S_LOW;
              end
            end else begin
              pos <= pos + CountW'(1);
            end
          end
        end
        S_SHIFT: begin
          // Move entry sh-1 up to sh, then place the new one.
          if (rd_pend) begin
            rd_pend <= 1'b0;
            sh <= sh - CountW'(1);
          end else if (sh == pos) begin
            count <= count + CountW'(1);
            state <= S_OUT;
          end else begin
            rd_pend <= 1'b1;
          end
        end
        S_LOW: begin
          // Upper entry is in rdata; read the lower one.
          rd_pend <= 1'b0;
          state <= S_HIGH;
        end
        S_HIGH: begin
          if (!rd_pend) begin
            k0 <= rdata.key;
            v0 <= rdata.val;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (done_re && done_im) begin
            index_real_out <= lre;
            index_imag_out <= lim;
            sre <= lre;
            sim <= lim;
            state <= S_EPS1;
          end
        end
        S_EPS1: state <= S_EPS2;
        S_EPS2: begin
          if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            eps_real_out <= ere;
            eps_imag_out <= eim;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
